[sv/sv39_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sv39_pkg;

  localparam int unsigned PPN_W   = 44;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned PTE_W   = 64;
  localparam int unsigned SLOT_W  = 9;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned PPN_LSB = 10;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_MAP    = 2'd0;
  localparam cmd_t CMD_LOOKUP = 2'd1;
  localparam cmd_t CMD_FREE   = 2'd2;
  localparam cmd_t CMD_ALLOC  = 2'd3;

  typedef logic [STAT_W-1:0] stat_t;
  localparam stat_t ST_OK      = 3'd0;
  localparam stat_t ST_MAPPED  = 3'd1;
  localparam stat_t ST_NOTMAP  = 3'd2;
  localparam stat_t ST_NOPAGE  = 3'd3;
  localparam stat_t ST_OUTSIDE = 3'd4;
  localparam stat_t ST_QFULL   = 3'd5;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_BUMP = 1'b1;

  localparam logic [PTE_W-1:0] PTE_V   = 64'h1;
  localparam logic [PTE_W-1:0] PTE_RWX = 64'hE;
  localparam logic [PTE_W-1:0] PTE_U   = 64'h10;

  // Datapath operations issued by the controller.
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;  // capture command fields, root index
  localparam op_t OP_RD_ENTRY = 4'd2;  // issue read of entry at level
  localparam op_t OP_TAKE     = 4'd3;  // take page from queue or bump
  localparam op_t OP_ZERO     = 4'd4;  // write one zero entry, advance counter
  localparam op_t OP_LINK     = 4'd5;  // write table link, follow it
  localparam op_t OP_FOLLOW   = 4'd6;  // follow valid entry
  localparam op_t OP_LEAF     = 4'd7;  // write new leaf entry
  localparam op_t OP_PUSH     = 4'd8;  // queue a freed page
  localparam op_t OP_CLR      = 4'd9;  // reset clearing pass write
  localparam op_t OP_LVL_DN   = 4'd10; // step to next level

  typedef struct packed {
    op_t   op;
    logic  set_res;
    stat_t res_stat;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic root_in;      // root in store
    logic free_in;      // free page in store
    logic q_full;
    logic q_empty;
    logic bump_ok;
    logic ent_valid;    // registered read entry V bit
    logic ent_in;       // registered entry ppn in store
    logic zero_done;
    logic clr_done;
    logic lvl_leaf;     // walk at leaf level
  } dp_stat_t;

endpackage
`default_nettype wire

[sv/sv39_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module sv39_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/sv39_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module sv39_dp #(
  parameter int unsigned STORE_PAGES = 64,
  parameter int unsigned FREE_DEPTH  = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sv39_pkg::ctl_cmd_t       ctl,
  output sv39_pkg::dp_stat_t            st,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_sel,
  input  wire logic [63:0]              cfg_data,
  input  wire sv39_pkg::cmd_t           in_cmd,
  input  wire logic [sv39_pkg::VA_W-1:0]  in_va,
  input  wire logic [sv39_pkg::PPN_W-1:0] in_root,
  input  wire logic                     in_user,
  input  wire logic [sv39_pkg::PPN_W-1:0] in_free,
  output sv39_pkg::stat_t               res_status,
  output logic [sv39_pkg::PPN_W-1:0]    res_ppn,
  output logic [sv39_pkg::SLOT_W-1:0]   res_index,
  output logic [sv39_pkg::PTE_W-1:0]    res_entry
);
  localparam int unsigned IW = $clog2(STORE_PAGES);
  localparam int unsigned QW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FREE_DEPTH + 1);
  localparam int unsigned AW = IW + sv39_pkg::SLOT_W;
  localparam int unsigned BW = IW + 1;

  logic [sv39_pkg::PPN_W-1:0] base_r;
  logic [BW-1:0]              bump_r, bump_nxt;
  logic [QW-1:0]              head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [AW:0]                clr_r, clr_nxt;

  sv39_pkg::cmd_t             cmd_r;
  logic [sv39_pkg::VA_W-1:0]  va_r;
  logic                       user_r;
  logic [sv39_pkg::PPN_W-1:0] root_r;
  logic [sv39_pkg::PPN_W-1:0] free_r;
  logic [IW-1:0]              tbl_r, tbl_nxt, new_r, new_nxt;
  logic [1:0]                 lvl_r, lvl_nxt;
  logic [sv39_pkg::SLOT_W:0]  zc_r, zc_nxt;
  logic [sv39_pkg::PTE_W-1:0] ent;
  logic [sv39_pkg::PTE_W-1:0] link_e, leaf_e;

  logic [sv39_pkg::PPN_W-1:0] root_d, free_d, ent_d, new_ppn, tbl_ppn;
  logic [sv39_pkg::SLOT_W-1:0] slot;
  logic                       ram_we;
  logic [AW-1:0]              waddr, raddr;
  logic [sv39_pkg::PTE_W-1:0] wdata;
  logic [IW-1:0]              q_rdata;
  logic                       q_we;

  assign root_d = root_r - base_r;
  assign free_d = free_r - base_r;
  assign ent_d  = ent[sv39_pkg::PPN_LSB +: sv39_pkg::PPN_W] - base_r;
  assign new_ppn = base_r + sv39_pkg::PPN_W'(new_r);
  assign tbl_ppn = base_r + sv39_pkg::PPN_W'(tbl_r);

  always_comb begin
    unique case (lvl_r)
      2'd2:    slot = va_r[38:30];
      2'd1:    slot = va_r[29:21];
      default: slot = va_r[20:12];
    endcase
  end

  assign link_e = {10'd0, new_ppn, 10'd0} | sv39_pkg::PTE_V |
                  (user_r ? sv39_pkg::PTE_U : '0);
  assign leaf_e = link_e | sv39_pkg::PTE_RWX;

  always_comb begin
    st.cmd       = cmd_r;
    st.root_in   = root_d < sv39_pkg::PPN_W'(STORE_PAGES);
    st.free_in   = free_d < sv39_pkg::PPN_W'(STORE_PAGES);
    st.q_full    = cnt_r == CW'(FREE_DEPTH);
    st.q_empty   = cnt_r == '0;
    st.bump_ok   = (bump_r + BW'(1)) < BW'(STORE_PAGES);
    st.ent_valid = ent[0];
    st.ent_in    = ent_d < sv39_pkg::PPN_W'(STORE_PAGES);
    st.zero_done = zc_r[sv39_pkg::SLOT_W];
    st.clr_done  = clr_r[AW];
    st.lvl_leaf  = lvl_r == 2'd0;
  end

  always_comb begin
    bump_nxt = bump_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    clr_nxt  = clr_r;
    tbl_nxt  = tbl_r;
    new_nxt  = new_r;
    lvl_nxt  = lvl_r;
    zc_nxt   = zc_r;
    ram_we   = 1'b0;
    waddr    = {tbl_r, slot};
    wdata    = '0;
    q_we     = 1'b0;
    unique case (ctl.op)
      sv39_pkg::OP_LOAD: begin
        // Low bits of the distance from base are the store index.
        tbl_nxt = in_root[IW-1:0] - base_r[IW-1:0];
        lvl_nxt = 2'd2;
      end
      sv39_pkg::OP_TAKE: begin
        zc_nxt = '0;
        if (cnt_r != '0) begin
          new_nxt  = q_rdata;
          head_nxt = (head_r == QW'(FREE_DEPTH - 1)) ? '0 : head_r + QW'(1);
          cnt_nxt  = cnt_r - CW'(1);
        end else begin
          bump_nxt = bump_r + BW'(1);
          new_nxt  = IW'(bump_r + BW'(1));
        end
      end
      sv39_pkg::OP_ZERO: begin
        ram_we = 1'b1;
        waddr  = {new_r, zc_r[sv39_pkg::SLOT_W-1:0]};
        zc_nxt = zc_r + 1'b1;
      end
      sv39_pkg::OP_LINK: begin
        ram_we  = 1'b1;
        wdata   = link_e;
        tbl_nxt = new_r;
        lvl_nxt = lvl_r - 2'd1;
      end
      sv39_pkg::OP_FOLLOW: begin
        tbl_nxt = ent_d[IW-1:0];
        lvl_nxt = lvl_r - 2'd1;
      end
      sv39_pkg::OP_LEAF: begin
        ram_we = 1'b1;
        wdata  = leaf_e;
      end
      sv39_pkg::OP_PUSH: begin
        q_we     = 1'b1;
        tail_nxt = (tail_r == QW'(FREE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
        cnt_nxt  = cnt_r + CW'(1);
      end
      sv39_pkg::OP_CLR: begin
        ram_we  = 1'b1;
        waddr   = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (cfg_we && cfg_sel == sv39_pkg::CFG_BUMP) begin
      bump_nxt = BW'(cfg_data[5:0]);
    end
  end

  assign raddr = {tbl_r, slot};

  sv39_ram #(.WIDTH(sv39_pkg::PTE_W), .DEPTH(STORE_PAGES * 512)) u_store (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(ent)
  );

  // Freed queue: read address is the head; read data is registered.
  sv39_ram #(.WIDTH(IW), .DEPTH(1 << QW)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail_r), .wdata(free_d[IW-1:0]),
    .raddr(head_r), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      bump_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      clr_r  <= '0;
    end else begin
      if (cfg_we && cfg_sel == sv39_pkg::CFG_BASE) begin
        base_r <= cfg_data[sv39_pkg::PPN_W-1:0];
      end
      bump_r <= bump_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      clr_r  <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tbl_r <= tbl_nxt;
    new_r <= new_nxt;
    lvl_r <= lvl_nxt;
    zc_r  <= zc_nxt;
    if (ctl.op == sv39_pkg::OP_LOAD) begin
      cmd_r  <= in_cmd;
      va_r   <= in_va;
      user_r <= in_user;
      root_r <= in_root;
      free_r <= in_free;
    end
    if (ctl.set_res) begin
      res_status <= ctl.res_stat;
      res_ppn    <= '0;
      res_index  <= '0;
      res_entry  <= '0;
      if (ctl.res_stat == sv39_pkg::ST_OK || ctl.res_stat == sv39_pkg::ST_MAPPED) begin
        unique case (cmd_r)
          sv39_pkg::CMD_ALLOC: res_ppn <= new_ppn;
          sv39_pkg::CMD_FREE:  res_ppn <= free_r;
          default: begin
            res_index <= va_r[20:12];
            if (ctl.op == sv39_pkg::OP_LEAF) begin
              res_ppn   <= new_ppn;
              res_entry <= leaf_e;
            end else begin
              res_ppn   <= tbl_ppn;
              res_entry <= ent;
            end
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[sv/sv39_ctl.sv]
`timescale 1ns / 1ps
`default_nettype none
module sv39_ctl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    busy,
  output sv39_pkg::ctl_cmd_t      ctl,
  input  wire sv39_pkg::dp_stat_t st
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_ZERO  = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_QWAIT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;

  assign out_valid = ovld_r;
  // One command at a time; the output register frees up once taken.
  assign in_stall  = !(state_r == S_IDLE && (!ovld_r || !out_stall));
  assign busy      = state_r != S_IDLE;

  always_comb begin
    state_nxt    = state_r;
    ovld_nxt     = ovld_r && out_stall;
    ctl.op       = sv39_pkg::OP_NONE;
    ctl.set_res  = 1'b0;
    ctl.res_stat = sv39_pkg::ST_OK;
    unique case (state_r)
      S_CLR: begin
        ctl.op = sv39_pkg::OP_CLR;
        if (st.clr_done) begin
          ctl.op    = sv39_pkg::OP_NONE;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          ctl.op    = sv39_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt   = S_OUT;
        ctl.set_res = 1'b1;
        unique case (st.cmd)
          sv39_pkg::CMD_ALLOC: begin
            if (st.q_empty && !st.bump_ok) begin
              ctl.res_stat = sv39_pkg::ST_NOPAGE;
            end else begin
              ctl.set_res = 1'b0;
              state_nxt   = S_QWAIT;
            end
          end
          sv39_pkg::CMD_FREE: begin
            if (!st.free_in) begin
              ctl.res_stat = sv39_pkg::ST_OUTSIDE;
            end else if (st.q_full) begin
              ctl.res_stat = sv39_pkg::ST_QFULL;
            end else begin
              ctl.op = sv39_pkg::OP_PUSH;
            end
          end
          default: begin
            if (!st.root_in) begin
              ctl.res_stat = sv39_pkg::ST_OUTSIDE;
            end else begin
              ctl.set_res = 1'b0;
              state_nxt   = S_RD;
            end
          end
        endcase
      end
      S_RD: state_nxt = S_CHK;
      S_QWAIT: begin
        ctl.op    = sv39_pkg::OP_TAKE;
        state_nxt = S_ZERO;
      end
      S_CHK: begin
        if (st.ent_valid) begin
          if (st.lvl_leaf) begin
            ctl.set_res  = 1'b1;
            ctl.res_stat = (st.cmd == sv39_pkg::CMD_MAP) ? sv39_pkg::ST_MAPPED
                                                         : sv39_pkg::ST_OK;
            state_nxt    = S_OUT;
          end else if (!st.ent_in) begin
            ctl.set_res  = 1'b1;
            ctl.res_stat = sv39_pkg::ST_OUTSIDE;
            state_nxt    = S_OUT;
          end else begin
            ctl.op    = sv39_pkg::OP_FOLLOW;
            state_nxt = S_RD;
          end
        end else if (st.cmd == sv39_pkg::CMD_LOOKUP) begin
          ctl.set_res  = 1'b1;
          ctl.res_stat = sv39_pkg::ST_NOTMAP;
          state_nxt    = S_OUT;
        end else if (st.q_empty && !st.bump_ok) begin
          ctl.set_res  = 1'b1;
          ctl.res_stat = sv39_pkg::ST_NOPAGE;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_QWAIT;
        end
      end
      S_ZERO: begin
        if (st.zero_done) begin
          state_nxt = S_DONE;
        end else begin
          ctl.op = sv39_pkg::OP_ZERO;
        end
      end
      S_DONE: begin
        if (st.cmd == sv39_pkg::CMD_ALLOC) begin
          ctl.set_res = 1'b1;
          state_nxt   = S_OUT;
        end else if (st.lvl_leaf) begin
          ctl.op      = sv39_pkg::OP_LEAF;
          ctl.set_res = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          ctl.op    = sv39_pkg::OP_LINK;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        ovld_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && out_stall) |=> ovld_r) else $error("result dropped");
  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == sv39_pkg::OP_LOAD) |=> (state_r == S_DISP)) else $error("load");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (!ovld_r || !out_stall)) else $error("overwrite");
endmodule
`default_nettype wire

[sv/sv39_page_table_map_and_walk_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel | direction | handshake           | payload
// in_     | input     | in_valid/in_stall   | command, virt_addr, root_ppn, user_mode, free_ppn
// out_    | output    | out_valid/out_stall | status, page_ppn, entry_index, leaf_entry
// cfg_    | input     | cfg_valid/cfg_ready | index (0 base_ppn, 1 bump_start), data
//
// One command at a time. Allocate zeroes the 512 entries of the new page with one
// store write per cycle; map zeroes up to three pages and does one read per level
// through the single read port of the store. After reset a clearing pass writes
// every store entry with in_stall high. A result waits in the output register while
// out_stall holds; the next command is taken in the same cycle the result transfers.
module sv39_page_table_map_and_walk_unit #(
  parameter int unsigned STORE_PAGES = 64,
  parameter int unsigned FREE_DEPTH  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [38:0] in_virt_addr,
  input  wire logic [43:0] in_root_ppn,
  input  wire logic        in_user_mode,
  input  wire logic [43:0] in_free_ppn,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [43:0]      out_page_ppn,
  output logic [8:0]       out_entry_index,
  output logic [63:0]      out_leaf_entry,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  sv39_pkg::ctl_cmd_t ctl;
  sv39_pkg::dp_stat_t st;
  logic               busy;

  // Config is always taken; writes only land when idle by contract.
  assign cfg_ready = 1'b1;

  sv39_ctl u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .busy(busy), .ctl(ctl), .st(st)
  );

  sv39_dp #(.STORE_PAGES(STORE_PAGES), .FREE_DEPTH(FREE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index[0]), .cfg_data(cfg_data),
    .in_cmd(in_command), .in_va(in_virt_addr), .in_root(in_root_ppn),
    .in_user(in_user_mode), .in_free(in_free_ppn),
    .res_status(out_status), .res_ppn(out_page_ppn), .res_index(out_entry_index),
    .res_entry(out_leaf_entry)
  );

  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !busy) else $error("accept while busy");
endmodule
`default_nettype wire
